[design/cdo_pkg.sv]
// Shared types, constants and the control store for the calendar date offset core.
// Depends on nothing; every other file in the design folder imports it.
package cdo_pkg;

    localparam int CDO_MAX_YEAR_DEF = 9999;

    localparam int YEAR_IN_W   = 14;
    localparam int MONTH_W     = 4;
    localparam int DAY_IN_W    = 5;
    localparam int OFFSET_W    = 17;
    localparam int DAY_W       = 18;  // day plus offset, signed
    localparam int CENT_W      = 10;  // year / 100 for years up to 65535
    localparam int REM_W       = 7;   // year % 100
    localparam int WIDE_W      = 17;  // room for any year plus sign during the split

    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 24;

    // Division of a year below 43699 by 100 as multiply and shift.
    localparam int DIV100_MUL   = 5243;
    localparam int DIV100_SHIFT = 19;
    localparam int DIV100_PROD_W = YEAR_IN_W + 13;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
    localparam logic [REM_W-1:0]   REM_LAST  = 7'd99;

    typedef logic [2:0] step_t;
    localparam step_t STEP_IDLE  = 3'd0;
    localparam step_t STEP_SPLIT = 3'd1;
    localparam step_t STEP_FWD   = 3'd2;
    localparam step_t STEP_BWD   = 3'd3;
    localparam step_t STEP_EMIT  = 3'd4;

    typedef enum logic [2:0] {
        OP_LOAD,
        OP_SPLIT,
        OP_FWD,
        OP_BWD,
        OP_EMIT
    } op_t;

    typedef enum logic [2:0] {
        COND_ALWAYS,
        COND_IN_VALID,
        COND_DAY_OVER,
        COND_DAY_UNDER,
        COND_OUT_FREE
    } cond_t;

    // One control word: the operation runs when the condition holds, and the
    // step counter then takes jmp_true, otherwise jmp_false.
    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t jmp_true;
        step_t jmp_false;
    } ctrl_t;

    function automatic ctrl_t ucode_rom(input step_t step);
        ctrl_t w;
        unique case (step)
            STEP_IDLE:  w = '{OP_LOAD,  COND_IN_VALID,  STEP_SPLIT, STEP_IDLE};
            STEP_SPLIT: w = '{OP_SPLIT, COND_ALWAYS,    STEP_FWD,   STEP_FWD};
            STEP_FWD:   w = '{OP_FWD,   COND_DAY_OVER,  STEP_FWD,   STEP_BWD};
            STEP_BWD:   w = '{OP_BWD,   COND_DAY_UNDER, STEP_BWD,   STEP_EMIT};
            STEP_EMIT:  w = '{OP_EMIT,  COND_OUT_FREE,  STEP_IDLE,  STEP_EMIT};
            default:    w = '{OP_EMIT,  COND_ALWAYS,    STEP_IDLE,  STEP_IDLE};
        endcase
        return w;
    endfunction

    // Month length; leap selects the long February.
    function automatic logic [DAY_IN_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                       input logic leap);
        logic [DAY_IN_W-1:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            MONTH_FEB: len = leap ? 5'd29 : 5'd28;
            default:   len = 5'd30;
        endcase
        return len;
    endfunction

endpackage

[design/calendar_date_offset_core.sv]
// Calendar date offset core: top level with the control store sequencer and datapath.
// Depends on cdo_pkg for widths, step codes, the control store and the month table.

// Adds a signed day count to a Gregorian date and returns the shifted date. After a
// transaction is accepted the core splits the year into hundreds and remainder, walks
// forward and then backward one month at a time, and writes the result to the output
// register; the input is ready again only after that. The month-walk step adds or
// subtracts one month length per cycle. The next item is taken as soon as the previous
// result is in the output register, even while that result still waits. Years leaving
// 1..MAX_YEAR saturate to the range end and raise m_tuser.
module calendar_date_offset_core
    import cdo_pkg::*;
#(
    parameter int MAX_YEAR = CDO_MAX_YEAR_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // year_in, month_in, day_in, day_offset
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // year_out, month_out, day_out, zero pad
    output logic                 m_tuser    // out_of_range
);

    localparam int YW = $clog2(MAX_YEAR + 1);
    localparam logic [YW-1:0] YEAR_MAX = YW'(MAX_YEAR);
    localparam logic [YW-1:0] YEAR_ONE = YW'(1);

    logic [YEAR_IN_W-1:0]       s_year;
    logic [MONTH_W-1:0]         s_month;
    logic [DAY_IN_W-1:0]        s_day;
    logic signed [OFFSET_W-1:0] s_offset;

    assign s_year   = s_tdata[13:0];
    assign s_month  = s_tdata[17:14];
    assign s_day    = s_tdata[22:18];
    assign s_offset = s_tdata[39:23];

    step_t                    step_reg, step_next;
    logic [YW-1:0]            year_reg, year_next;
    logic [CENT_W-1:0]        cent_reg, cent_next;
    logic [REM_W-1:0]         rem_reg, rem_next;
    logic [MONTH_W-1:0]       month_reg, month_next;
    logic signed [DAY_W-1:0]  day_reg, day_next;
    logic                     flag_reg, flag_next;
    logic                     out_valid_reg, out_valid_next;
    logic [YEAR_IN_W-1:0]     out_year_reg, out_year_next;
    logic [MONTH_W-1:0]       out_month_reg, out_month_next;
    logic [DAY_IN_W-1:0]      out_day_reg, out_day_next;
    logic                     out_flag_reg, out_flag_next;

    ctrl_t                    ctrl;
    logic                     cond_true;
    logic                     leap;
    logic [DAY_IN_W-1:0]      cur_len;
    logic [MONTH_W-1:0]       prev_month;
    logic [DAY_IN_W-1:0]      prev_len;
    logic [YEAR_IN_W-1:0]     year_clamp;
    logic [MONTH_W-1:0]       month_clamp;
    logic [DIV100_PROD_W-1:0] div_prod;
    logic [WIDE_W-1:0]        split_rem;
    logic                     out_free;

    assign ctrl = ucode_rom(step_reg);

    // Leap test from the year split into hundreds and remainder.
    assign leap     = (rem_reg != '0) ? (rem_reg[1:0] == 2'b00) : (cent_reg[1:0] == 2'b00);
    assign cur_len  = month_len(month_reg, leap);
    assign prev_month = (month_reg == MONTH_JAN) ? MONTH_DEC : month_reg - MONTH_JAN;
    assign prev_len = month_len(prev_month, leap);

    always_comb begin
        if (s_year == '0) begin
            year_clamp = YEAR_IN_W'(1);
        end else if (32'(s_year) > MAX_YEAR) begin
            year_clamp = YEAR_IN_W'(MAX_YEAR);
        end else begin
            year_clamp = s_year;
        end
        if (s_month == '0) begin
            month_clamp = MONTH_JAN;
        end else if (s_month > MONTH_DEC) begin
            month_clamp = MONTH_DEC;
        end else begin
            month_clamp = s_month;
        end
    end

    assign div_prod  = DIV100_PROD_W'(year_clamp) * DIV100_PROD_W'(DIV100_MUL);
    assign split_rem = WIDE_W'(year_reg) - WIDE_W'(cent_reg) * WIDE_W'(100);
    assign out_free  = !out_valid_reg || m_tready;

    always_comb begin
        case (ctrl.cond)
            COND_ALWAYS:    cond_true = 1'b1;
            COND_IN_VALID:  cond_true = s_tvalid;
            COND_DAY_OVER:  cond_true = day_reg > $signed({13'b0, cur_len});
            COND_DAY_UNDER: cond_true = day_reg < $signed(DAY_W'(1));
            COND_OUT_FREE:  cond_true = out_free;
            default:        cond_true = 1'b0;
        endcase
    end

    always_comb begin
        step_next      = cond_true ? ctrl.jmp_true : ctrl.jmp_false;
        year_next      = year_reg;
        cent_next      = cent_reg;
        rem_next       = rem_reg;
        month_next     = month_reg;
        day_next       = day_reg;
        flag_next      = flag_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_year_next  = out_year_reg;
        out_month_next = out_month_reg;
        out_day_next   = out_day_reg;
        out_flag_next  = out_flag_reg;

        if (cond_true) begin
            unique case (ctrl.op)
                OP_LOAD: begin
                    year_next  = YW'(year_clamp);
                    cent_next  = CENT_W'(div_prod >> DIV100_SHIFT);
                    month_next = month_clamp;
                    day_next   = $signed({13'b0, s_day}) + DAY_W'(s_offset);
                    flag_next  = 1'b0;
                end
                OP_SPLIT: begin
                    rem_next = REM_W'(split_rem);
                end
                OP_FWD: begin
                    day_next = day_reg - $signed({13'b0, cur_len});
                    if (month_reg == MONTH_DEC) begin
                        if (year_reg >= YEAR_MAX) begin
                            // Past the last year: pin to its last day.
                            year_next  = YEAR_MAX;
                            month_next = MONTH_DEC;
                            day_next   = DAY_W'(31);
                            flag_next  = 1'b1;
                        end else begin
                            month_next = MONTH_JAN;
                            year_next  = year_reg + YEAR_ONE;
                            if (rem_reg == REM_LAST) begin
                                rem_next  = '0;
                                cent_next = cent_reg + CENT_W'(1);
                            end else begin
                                rem_next = rem_reg + REM_W'(1);
                            end
                        end
                    end else begin
                        month_next = month_reg + MONTH_JAN;
                    end
                end
                OP_BWD: begin
                    if (month_reg == MONTH_JAN) begin
                        if (year_reg <= YEAR_ONE) begin
                            year_next  = YEAR_ONE;
                            month_next = MONTH_JAN;
                            day_next   = DAY_W'(1);
                            flag_next  = 1'b1;
                        end else begin
                            // December is 31 days in every year.
                            month_next = MONTH_DEC;
                            year_next  = year_reg - YEAR_ONE;
                            day_next   = day_reg + DAY_W'(31);
                            if (rem_reg == '0) begin
                                rem_next  = REM_LAST;
                                cent_next = cent_reg - CENT_W'(1);
                            end else begin
                                rem_next = rem_reg - REM_W'(1);
                            end
                        end
                    end else begin
                        month_next = prev_month;
                        day_next   = day_reg + $signed({13'b0, prev_len});
                    end
                end
                OP_EMIT: begin
                    out_valid_next = 1'b1;
                    out_year_next  = YEAR_IN_W'(year_reg);
                    out_month_next = month_reg;
                    out_day_next   = DAY_IN_W'(day_reg);
                    out_flag_next  = flag_reg;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg      <= STEP_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
        year_reg      <= year_next;
        cent_reg      <= cent_next;
        rem_reg       <= rem_next;
        month_reg     <= month_next;
        day_reg       <= day_next;
        flag_reg      <= flag_next;
        out_year_reg  <= out_year_next;
        out_month_reg <= out_month_next;
        out_day_reg   <= out_day_next;
        out_flag_reg  <= out_flag_next;
    end

    assign s_tready = (step_reg == STEP_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_day_reg, out_month_reg, out_year_reg};
    assign m_tuser  = out_flag_reg;

`ifndef SYNTHESIS
    // The hundreds split must track the binary year through the month walk.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (step_reg == STEP_FWD || step_reg == STEP_BWD || step_reg == STEP_EMIT) |->
        (32'(cent_reg) * 100 + 32'(rem_reg) == 32'(year_reg)))
        else $error("year split out of step with year register");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (step_reg == STEP_FWD || step_reg == STEP_BWD) |->
        (month_reg >= MONTH_JAN && month_reg <= MONTH_DEC))
        else $error("month left 1..12 during the walk");

    // The forward walk leaves at most one month length behind.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (step_reg == STEP_BWD) |-> (day_reg <= $signed(DAY_W'(31))))
        else $error("backward walk entered with day above 31");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (step_reg == STEP_EMIT) |->
        (day_reg >= $signed(DAY_W'(1)) && day_reg <= $signed({13'b0, cur_len})))
        else $error("result day outside its month");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |->
        (32'(out_year_reg) == 1 || 32'(out_year_reg) == (MAX_YEAR % 16384)))
        else $error("range flag set on a year that is not a range end");
`endif

endmodule
